FILE: hw/rtl/sha_pkg.sv
// Package with the SHA-256 hasher's shared types, constants and round functions.
package sha_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int ROUNDS      = 64;
    localparam int LEN_OFFSET  = 56;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [1:0] {
        ACT_ABSORB        = 2'd0,
        ACT_ABSORB_FINISH = 2'd1,
        ACT_FINISH        = 2'd2,
        ACT_UNUSED        = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    // Control from the sequencer to the compression core.
    typedef struct packed {
        logic       start;
        logic       round_en;
        logic [5:0] round_idx;
        logic       add_en;
        logic       reset_chain;
    } core_ctrl_t;

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] r;
        case (i)
            3'd0:    r = 32'h6a09e667;
            3'd1:    r = 32'hbb67ae85;
            3'd2:    r = 32'h3c6ef372;
            3'd3:    r = 32'ha54ff53a;
            3'd4:    r = 32'h510e527f;
            3'd5:    r = 32'h9b05688c;
            3'd6:    r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] r;
        case (i)
            6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
            6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
            6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
            6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
            6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
            6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
            6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
            6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
            6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
            6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
            6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
            6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
            default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: hw/rtl/sha_buffer.sv
// Block buffer memory: byte writes, registered 32-bit word reads.
module sha_buffer
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        wr_en,
    input  logic [5:0]  wr_addr,
    input  logic [7:0]  wr_data,
    input  logic [3:0]  rd_addr,
    output logic [31:0] rd_data
);

    // Four byte lanes so that one word reads in one access.
    logic [7:0] lane0_mem [16];
    logic [7:0] lane1_mem [16];
    logic [7:0] lane2_mem [16];
    logic [7:0] lane3_mem [16];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            case (wr_addr[1:0])
                2'd0:    lane0_mem[wr_addr[5:2]] <= wr_data;
                2'd1:    lane1_mem[wr_addr[5:2]] <= wr_data;
                2'd2:    lane2_mem[wr_addr[5:2]] <= wr_data;
                default: lane3_mem[wr_addr[5:2]] <= wr_data;
            endcase
        end
        rd_data <= {lane0_mem[rd_addr], lane1_mem[rd_addr],
                    lane2_mem[rd_addr], lane3_mem[rd_addr]};
    end

endmodule

FILE: hw/rtl/sha_core.sv
// Compression core: message schedule window, round registers and chaining memory.
module sha_core
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  core_ctrl_t  ctrl,
    input  logic [31:0] buf_word,
    input  logic [2:0]  chain_rd_idx,
    output logic [31:0] chain_word
);

    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] w_cur;
    logic [31:0] w_new;
    logic [31:0] big0, big1, choose, major, t1, t2;
    logic [31:0] x, y;

    // Schedule: the first sixteen words come from the buffer, the rest are expanded.
    always_comb
    begin
        x = w_reg[1];
        y = w_reg[14];
        w_new = w_reg[0] + (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3)) + w_reg[9]
              + (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10));
        w_cur = (ctrl.round_idx < 6'd16) ? buf_word : w_new;
        big1 = ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25);
        choose = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + big1 + choose + round_k(ctrl.round_idx) + w_cur;
        big0 = ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22);
        major = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = big0 + major;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= init_h(3'(i));
        end
        else if (ctrl.reset_chain)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= init_h(3'(i));
        end
        else if (ctrl.add_en)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= h_reg[i] + v_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        else if (ctrl.round_en)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_cur;
        end
    end

    assign chain_word = h_reg[chain_rd_idx];

endmodule

FILE: hw/rtl/sha256_stream_hasher.sv
// Top level of the byte-stream SHA-256 hasher.
// Usage: in_valid/in_ready carry one in_item_t transaction (action, data_byte).
// Action absorb writes the byte into the block buffer; absorb-finish writes it
// and then pads; finish pads with no byte; the unused code is dropped.
// An absorb that completes a 64-byte block also runs a compression (buffer
// read, 64 rounds, chaining add), all through the one round unit. A finish
// writes the padding one byte per cycle, pausing for each compression (up to
// 72 bytes plus one or two compressions), then offers the eight digest words
// on out_valid/out_ready, index 0 first, last_word set on index 7.
// No new input is taken while a block is being compressed.
// While out_valid is high and out_ready is low, the block holds the word and
// takes no new input; after the eighth word it returns to the initial hash value.
// Reset (rst_n low) restores the initial hash value, an empty buffer and a
// zero length; buffer contents are left undefined.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    state_t      state_reg, state_next, ret_reg, ret_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [3:0]  pad_reg, pad_next;
    logic        padding_reg, padding_next;
    logic        wrap_reg, wrap_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [7:0]  wr_data;
    logic [3:0]  rd_addr;
    logic [31:0] buf_word;
    logic [31:0] chain_word;
    logic [63:0] bits;
    core_ctrl_t  ctrl;
    logic        accept;

    assign accept = in_valid && in_ready;
    assign bits = {len_reg[60:0], 3'b000};

    sha_buffer u_buf (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(buf_word)
    );

    sha_core u_core (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .buf_word(buf_word),
        .chain_rd_idx(oidx_reg), .chain_word(chain_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg <= ST_IDLE;
            fill_reg <= '0;
            len_reg <= '0;
            rnd_reg <= '0;
            pad_reg <= '0;
            padding_reg <= 1'b0;
            wrap_reg <= 1'b0;
            oidx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            fill_reg <= fill_next;
            len_reg <= len_next;
            rnd_reg <= rnd_next;
            pad_reg <= pad_next;
            padding_reg <= padding_next;
            wrap_reg <= wrap_next;
            oidx_reg <= oidx_next;
        end
    end

    // Next state and counters.
    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        fill_next = fill_reg;
        len_next = len_reg;
        rnd_next = rnd_reg;
        pad_next = pad_reg;
        padding_next = padding_reg;
        wrap_next = wrap_reg;
        oidx_next = oidx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_data.action != ACT_UNUSED)
                begin
                    if (in_data.action != ACT_FINISH)
                    begin
                        fill_next = fill_reg + 6'd1;
                        len_next = len_reg + 64'd1;
                    end
                    ret_next = (in_data.action == ACT_ABSORB) ? ST_IDLE : ST_PAD;
                    padding_next = 1'b0;
                    wrap_next = 1'b0;
                    pad_next = '0;
                    if (in_data.action != ACT_FINISH && fill_reg == 6'd63)
                    begin
                        state_next = ST_LOAD;
                        rnd_next = '0;
                    end
                    else
                        state_next = ret_next;
                end
            end
            ST_PAD:
            begin
                // One padding byte per cycle outside compressions: marker, zeros, then the length.
                // A marker that lands inside the length field forces zeros up to
                // the end of this block before the length goes in the next one.
                fill_next = fill_reg + 6'd1;
                if (!padding_reg)
                begin
                    padding_next = 1'b1;
                    wrap_next = (fill_reg >= 6'(LEN_OFFSET)) && (fill_reg != 6'd63);
                end
                else if (wrap_reg)
                begin
                    if (fill_reg == 6'd63)
                        wrap_next = 1'b0;
                end
                else if (fill_reg >= 6'(LEN_OFFSET))
                    pad_next = pad_reg + 4'd1;
                if (padding_reg && pad_reg == 4'd7)
                    ret_next = ST_OUT;
                else
                    ret_next = ST_PAD;
                if (fill_reg == 6'd63)
                begin
                    state_next = ST_LOAD;
                    rnd_next = '0;
                end
                else
                    state_next = ret_next;
            end
            ST_LOAD:
                state_next = ST_ROUND;
            ST_ROUND:
            begin
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == 7'(ROUNDS - 1))
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = ret_reg;
                oidx_next = '0;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                        len_next = '0;
                        fill_next = '0;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath control.
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        out_data.digest_word = chain_word;
        out_data.word_index = oidx_reg;
        out_data.last_word = (oidx_reg == 3'd7);
        wr_en = 1'b0;
        wr_addr = fill_reg;
        wr_data = in_data.data_byte;
        rd_addr = rnd_reg[3:0];
        ctrl = '0;
        case (state_reg)
            ST_IDLE:
                wr_en = accept && (in_data.action == ACT_ABSORB
                                   || in_data.action == ACT_ABSORB_FINISH);
            ST_PAD:
            begin
                wr_en = 1'b1;
                if (!padding_reg)
                    wr_data = PAD_BYTE;
                else if (fill_reg >= 6'(LEN_OFFSET) && !wrap_reg)
                    wr_data = bits[8 * (7 - int'(pad_reg[2:0])) +: 8];
                else
                    wr_data = 8'h00;
            end
            ST_LOAD:
            begin
                ctrl.start = 1'b1;
                rd_addr = '0;
            end
            ST_ROUND:
            begin
                ctrl.round_en = 1'b1;
                ctrl.round_idx = rnd_reg[5:0];
                rd_addr = 4'(rnd_reg + 7'd1);
            end
            ST_ADD:
                ctrl.add_en = 1'b1;
            ST_OUT:
                ctrl.reset_chain = out_ready && oidx_reg == 3'd7;
            default: ;
        endcase
    end

endmodule
